[rtl/bdhl_pkg.sv]
// shared types and constants of the button debounce hold-level core
package bdhl_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned LEVELS    = 4;
	localparam int unsigned EV_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD4    = 3'd4;

	localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd30;
	localparam logic [CFG_W-1:0] RST_HOLD1    = 16'd5000;
	localparam logic [CFG_W-1:0] RST_HOLD2    = 16'd15000;
	localparam logic [CFG_W-1:0] RST_HOLD3    = 16'd30000;
	localparam logic [CFG_W-1:0] RST_HOLD4    = 16'd60000;

	localparam logic [EV_W-1:0] EV_IDLE     = 3'd0;
	localparam logic [EV_W-1:0] EV_PRESSED  = 3'd1;
	localparam logic [EV_W-1:0] EV_RELEASED = 3'd2;
	localparam logic [EV_W-1:0] EV_HELD     = 3'd3;
	localparam logic [EV_W-1:0] EV_LEVEL1   = 3'd4;

	typedef logic [CFG_W-1:0] thr_t;

	typedef struct packed {
		logic       fire;
		logic [1:0] level;
	} hold_hit_t;

endpackage

[rtl/bdhl_hold_sel.sv]
// hold-level selection: highest due level that has not fired yet
module bdhl_hold_sel import bdhl_pkg::*; #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic [TIMER_WIDTH-1:0] elapsed,
	input  thr_t [LEVELS-1:0]      thr,
	input  logic [LEVELS-1:0]      flags,
	output hold_hit_t              hit
);

	localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

	logic [CMP_W-1:0]  t_ext;
	logic [LEVELS-1:0] due;

	assign t_ext = CMP_W'(elapsed);

	always_comb begin
		for (int k = 0; k < LEVELS; k++) begin
			due[k] = (t_ext >= CMP_W'(thr[k])) && !flags[k];
		end
	end

	always_comb begin
		hit = '0;
		priority if (due[3]) begin
			hit = '{fire: 1'b1, level: 2'd3};
		end else if (due[2]) begin
			hit = '{fire: 1'b1, level: 2'd2};
		end else if (due[1]) begin
			hit = '{fire: 1'b1, level: 2'd1};
		end else if (due[0]) begin
			hit = '{fire: 1'b1, level: 2'd0};
		end else begin
			hit = '0;
		end
	end

endmodule

[rtl/button_debounce_hold_levels_core.sv]
// top level: button debounce with four hold levels, one event per tick
// output: an event is registered and appears on the master side in the cycle after its tick transaction
// throughput: one tick per cycle while the master side takes events; the state update and event decode
// are combinational between the state registers and the output register
// reset: asynchronous, active low; registers other than the event code return to their defaults, timer running at zero
// the output register holds a finished event while the next tick is already being taken
module button_debounce_hold_levels_core import bdhl_pkg::*; #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [0] pin_level
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata    // [2:0] event_code
);

	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

	thr_t                    debounce_q;
	thr_t [LEVELS-1:0]       hold_thr_q;
	logic                    pressed_q;
	logic [LEVELS-1:0]       hold_flags_q;
	logic [TIMER_WIDTH-1:0]  elapsed_q;
	logic                    running_q;
	logic                    out_valid_q;
	logic [EV_W-1:0]         out_code_q;

	logic                    s_accept;
	logic                    level;
	logic                    db_met;
	hold_hit_t               hit;
	logic                    pressed_d;
	logic [LEVELS-1:0]       hold_flags_d;
	logic [TIMER_WIDTH-1:0]  elapsed_mid;
	logic [TIMER_WIDTH-1:0]  elapsed_d;
	logic                    running_d;
	logic [EV_W-1:0]         ev;

	localparam int unsigned CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

	assign s_tready = !out_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign level    = s_tdata[0];
	assign db_met   = CMP_W'(elapsed_q) >= CMP_W'(debounce_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8 - EV_W){1'b0}}, out_code_q};

	bdhl_hold_sel #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_hold_sel (
		.elapsed(elapsed_q),
		.thr    (hold_thr_q),
		.flags  (hold_flags_q),
		.hit    (hit)
	);

	always_comb begin
		pressed_d    = pressed_q;
		hold_flags_d = hold_flags_q;
		elapsed_mid  = elapsed_q;
		running_d    = running_q;
		ev           = EV_IDLE;
		if (!pressed_q) begin
			if (level) begin
				running_d = 1'b1;
				if (db_met) begin
					pressed_d   = 1'b1;
					ev          = EV_PRESSED;
					elapsed_mid = '0;
				end
			end else begin
				running_d   = 1'b0;
				elapsed_mid = '0;
			end
		end else if (!level) begin
			running_d = 1'b1;
			if (db_met) begin
				pressed_d    = 1'b0;
				ev           = EV_RELEASED;
				hold_flags_d = '0;
				running_d    = 1'b0;
				elapsed_mid  = '0;
			end
		end else begin
			ev = EV_HELD;
			if (hit.fire) begin
				hold_flags_d[hit.level] = 1'b1;
				ev = {1'b1, hit.level};
			end
		end
		if (running_d && (elapsed_mid != TIMER_MAX)) begin
			elapsed_d = elapsed_mid + TIMER_WIDTH'(1);
		end else begin
			elapsed_d = elapsed_mid;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= RST_DEBOUNCE;
			hold_thr_q[0] <= RST_HOLD1;
			hold_thr_q[1] <= RST_HOLD2;
			hold_thr_q[2] <= RST_HOLD3;
			hold_thr_q[3] <= RST_HOLD4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q    <= cfg_data;
				REG_HOLD1:    hold_thr_q[0] <= cfg_data;
				REG_HOLD2:    hold_thr_q[1] <= cfg_data;
				REG_HOLD3:    hold_thr_q[2] <= cfg_data;
				REG_HOLD4:    hold_thr_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q    <= 1'b0;
			hold_flags_q <= '0;
			elapsed_q    <= '0;
			running_q    <= 1'b1;
		end else if (s_accept) begin
			pressed_q    <= pressed_d;
			hold_flags_q <= hold_flags_d;
			elapsed_q    <= elapsed_d;
			running_q    <= running_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_code_q <= ev;
		end
	end

`ifndef SYNTHESIS
	a_flags_need_press: assert property (@(posedge clk) disable iff (!arst_n)
		!pressed_q |-> (hold_flags_q == '0))
		else $error("hold flags set while not pressed");

	a_stopped_timer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (elapsed_q == '0))
		else $error("stopped timer not at zero");

	a_press_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (ev == EV_PRESSED)) |=>
		(pressed_q && running_q && (elapsed_q == TIMER_WIDTH'(1))))
		else $error("press did not restart timer");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (ev == EV_RELEASED)) |=>
		(!pressed_q && !running_q && (hold_flags_q == '0) && m_tvalid))
		else $error("release did not clear state");
`endif

endmodule

[bench/tb_button_debounce_hold_levels_core.sv]
// testbench for button_debounce_hold_levels_core: predicted events checked against the stream output
module tb_button_debounce_hold_levels_core;
	timeunit 1ns;
	timeprecision 1ps;
	import bdhl_pkg::*;

	localparam int unsigned TIMER_W     = 16;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [CFG_IDX_W-1:0] idx;
		thr_t                 val;
	} reg_write_t;

	class debounce_tracker;
		thr_t               debounce;
		thr_t               hold_thr [LEVELS];
		bit                 pressed;
		logic [LEVELS-1:0]  hold_flags;
		logic [TIMER_W-1:0] elapsed;
		bit                 running;
		logic [EV_W-1:0]    events_due [$];
		int unsigned        seen [8];
		int unsigned        errors;
		int unsigned        checked;

		function new();
			debounce    = RST_DEBOUNCE;
			hold_thr[0] = RST_HOLD1;
			hold_thr[1] = RST_HOLD2;
			hold_thr[2] = RST_HOLD3;
			hold_thr[3] = RST_HOLD4;
			pressed     = 1'b0;
			hold_flags  = '0;
			elapsed     = '0;
			running     = 1'b1;
			errors      = 0;
			checked     = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, thr_t v);
			case (idx)
				REG_DEBOUNCE: debounce = v;
				REG_HOLD1: hold_thr[0] = v;
				REG_HOLD2: hold_thr[1] = v;
				REG_HOLD3: hold_thr[2] = v;
				REG_HOLD4: hold_thr[3] = v;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return events_due.size();
		endfunction

		// decisions use the timer value from before the tick
		function void note_tick(bit level);
			logic [TIMER_W-1:0] t;
			logic [EV_W-1:0]    ev;
			t  = elapsed;
			ev = EV_IDLE;
			if (!pressed) begin
				if (level) begin
					running = 1'b1;
					if (t >= debounce) begin
						pressed = 1'b1;
						ev      = EV_PRESSED;
						elapsed = '0;
					end
				end else begin
					running = 1'b0;
					elapsed = '0;
				end
			end else if (!level) begin
				running = 1'b1;
				if (t >= debounce) begin
					pressed    = 1'b0;
					ev         = EV_RELEASED;
					hold_flags = '0;
					running    = 1'b0;
					elapsed    = '0;
				end
			end else begin
				ev = EV_HELD;
				// highest due level goes first
				for (int k = LEVELS - 1; k >= 0; k--) begin
					if (t >= hold_thr[k] && !hold_flags[k]) begin
						hold_flags[k] = 1'b1;
						ev            = EV_LEVEL1 + EV_W'(k);
						break;
					end
				end
			end
			if (running && elapsed != '1)
				elapsed = elapsed + TIMER_W'(1);
			events_due.push_back(ev);
		endfunction

		function void check_event(logic [7:0] data);
			logic [EV_W-1:0] exp_ev;
			if (events_due.size() == 0) begin
				$error("event_code: expected none, actual %0d", data[EV_W-1:0]);
				errors++;
				return;
			end
			exp_ev = events_due.pop_front();
			checked++;
			seen[exp_ev]++;
			if (data[EV_W-1:0] !== exp_ev) begin
				$error("event_code: expected %0d, actual %0d", exp_ev, data[EV_W-1:0]);
				errors++;
			end
			if (data[7:EV_W] !== '0) begin
				$error("m_tdata padding: expected 0, actual %0h", data[7:EV_W]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [7:0]           m_tdata;

	debounce_tracker tracker = new();

	bit          tx_steady    = 1'b0;
	bit          rx_steady    = 1'b0;
	int          rx_stall     = 0;
	int          rx_gap;
	int unsigned cycle_count  = 0;
	int unsigned ticks_sent   = 0;
	int unsigned settings_run = 0;

	button_debounce_hold_levels_core #(
		.TIMER_WIDTH(TIMER_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycle_count,
				tracker.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// transaction monitor: note ticks first, then check events
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_tick(s_tdata[0]);
			if (m_tvalid && m_tready)
				tracker.check_event(m_tdata);
		end
	end

	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// event receiver backpressure
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else begin
			rx_gap = pick_gap(1'b0);
			if (rx_gap == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_stall <= rx_gap - 1;
			end
		end
	end

	task automatic send_tick(bit level);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, level};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
	endtask

	task automatic send_run(bit level, int count);
		repeat (count) send_tick(level);
	endtask

	// hold the sender until every event has come back
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() > 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apply_writes(reg_write_t wr [$]);
		foreach (wr[i]) begin
			cfg_we    <= 1'b1;
			cfg_index <= wr[i].idx;
			cfg_data  <= wr[i].val;
			@(posedge clk);
			tracker.write_reg(wr[i].idx, wr[i].val);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(thr_t db, thr_t h1, thr_t h2, thr_t h3, thr_t h4, bit junk);
		reg_write_t wr [$];
		wr.push_back('{REG_DEBOUNCE, db});
		wr.push_back('{REG_HOLD1, h1});
		wr.push_back('{REG_HOLD2, h2});
		wr.push_back('{REG_HOLD3, h3});
		wr.push_back('{REG_HOLD4, h4});
		// unused indexes must leave the registers alone
		if (junk) begin
			wr.push_back('{CFG_IDX_W'(5), thr_t'($urandom)});
			wr.push_back('{CFG_IDX_W'(6), '1});
			wr.push_back('{CFG_IDX_W'(7), thr_t'($urandom)});
		end
		apply_writes(wr);
		settings_run++;
	endtask

	// press/hold/release sequences with random lengths, some bounce, some noise
	task automatic run_presses(int budget);
		int unsigned start;
		int          db_i;
		int          hmax;
		int          a;
		int          r;
		int          kind;
		bit          bouncy;
		start = ticks_sent;
		db_i  = (tracker.debounce > 60) ? 60 : int'(tracker.debounce);
		hmax  = 0;
		foreach (tracker.hold_thr[k])
			if (tracker.hold_thr[k] <= 80 && int'(tracker.hold_thr[k]) > hmax)
				hmax = int'(tracker.hold_thr[k]);
		while (ticks_sent - start < budget) begin
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				bouncy = ($urandom_range(0, 4) == 0);
				a = $urandom_range(1, db_i + hmax + 6);
				r = $urandom_range(1, db_i + 6);
				repeat (a) send_tick(!(bouncy && $urandom_range(0, 15) == 0));
				repeat (r) send_tick(bouncy && $urandom_range(0, 15) == 0);
			end else begin
				repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 39) == 0)
				drain_events();
		end
		drain_events();
	endtask

	task automatic random_phase(thr_t db, thr_t h1, thr_t h2, thr_t h3, thr_t h4, bit junk,
			int budget);
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		set_regs(db, h1, h2, h3, h4, junk);
		run_presses(budget);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults from reset, timer already running
		send_run(1'b1, 36);
		send_run(1'b0, 12);
		send_run(1'b0, 30);
		send_run(1'b0, 3);
		drain_events();

		// zero debounce and thresholds: immediate press, levels four down to one
		set_regs('0, '0, '0, '0, '0, 1'b0);
		send_tick(1'b0);
		send_run(1'b1, 6);
		send_run(1'b0, 2);
		drain_events();

		// early release ignored, full-scale thresholds never reached
		set_regs(16'd2, 16'd1, '1, 16'd3, '1, 1'b0);
		send_run(1'b1, 3);
		send_tick(1'b0);
		send_run(1'b1, 3);
		send_run(1'b0, 3);
		drain_events();

		random_phase(16'd3, 16'd5, 16'd10, 16'd15, 16'd20, 1'b0, 110);
		random_phase('0, '0, 16'd1, 16'd2, 16'd3, 1'b0, 110);
		random_phase(16'd1, 16'd4, 16'd4, 16'd4, 16'd4, 1'b1, 110);
		random_phase(16'd5, 16'd30, 16'd20, 16'd10, 16'd2, 1'b0, 110);
		random_phase(thr_t'($urandom_range(0, 6)), thr_t'($urandom_range(0, 40)),
			thr_t'($urandom_range(0, 40)), thr_t'($urandom_range(0, 40)),
			thr_t'($urandom_range(0, 40)), 1'b1, 110);
		random_phase('1, '1, '1, '1, '1, 1'b0, 40);
		random_phase(thr_t'($urandom_range(0, 6)), thr_t'($urandom_range(0, 40)),
			thr_t'($urandom_range(0, 40)), thr_t'($urandom_range(0, 40)),
			thr_t'($urandom_range(0, 40)), 1'b1, 110);
		random_phase(16'd2, 16'd1, '1, 16'd3, '1, 1'b0, 110);

		repeat (10) @(posedge clk);
		$display("%0d ticks sent, %0d events checked over %0d register settings",
			ticks_sent, tracker.checked, settings_run);
		$display("pressed %0d released %0d held %0d, hold levels 1-4: %0d %0d %0d %0d",
			tracker.seen[EV_PRESSED], tracker.seen[EV_RELEASED], tracker.seen[EV_HELD],
			tracker.seen[EV_LEVEL1], tracker.seen[EV_LEVEL1 + 1],
			tracker.seen[EV_LEVEL1 + 2], tracker.seen[EV_LEVEL1 + 3]);
		if (tracker.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
